FILE: hw/rtl/sdfts_pkg.sv
// ----------------------------------------------------------------------------
// SDF texture sampler package
// Field widths, operation codes and reset values shared by the sampler files.
// ----------------------------------------------------------------------------
`default_nettype none

package sdfts_pkg;

  localparam int OP_W      = 2;
  localparam int COORD_W   = 24;
  localparam int INDEX_W   = 14;
  localparam int CODE_W    = 8;
  localparam int SCALE_W   = 8;
  localparam int FRAC_BITS = 12;

  // Integer texel index after the fraction is dropped, one extra bit for rounding.
  localparam int IXW = COORD_W - FRAC_BITS + 1;

  localparam int HALF_TEXEL       = 2048;
  localparam int CODE_MAX         = 255;
  localparam int TEXTURE_SIZE_DEF = 128;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd4;

  localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
  localparam logic [OP_W-1:0] OP_BILINEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_NEAREST  = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/sdfts_in_if.sv
// ----------------------------------------------------------------------------
// Sampler request channel
// Valid/ready channel that carries texel writes and sample requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdfts_in_if import sdfts_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [COORD_W-1:0] coord_u;
  logic signed [COORD_W-1:0] coord_w;
  logic [INDEX_W-1:0]        texel_index;
  logic [CODE_W-1:0]         texel_value;

  modport source (
    output valid, operation, coord_u, coord_w, texel_index, texel_value,
    input  ready
  );

  modport sink (
    input  valid, operation, coord_u, coord_w, texel_index, texel_value,
    output ready
  );

endinterface

`default_nettype wire

FILE: hw/rtl/sdfts_out_if.sv
// ----------------------------------------------------------------------------
// Sampler result channel
// Valid/ready channel that carries one distance code per sample beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdfts_out_if import sdfts_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] distance;

  modport source (
    output valid, distance,
    input  ready
  );

  modport sink (
    input  valid, distance,
    output ready
  );

endinterface

`default_nettype wire

FILE: hw/rtl/sdfts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports sharing a read enable, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sdf_texture_sampler_unit.sv
// ----------------------------------------------------------------------------
// SDF texture sampler
// Bilinear and nearest sampling of a square 8-bit distance texture with
// clamp-to-edge and a distance penalty per texel of overshoot.
// ----------------------------------------------------------------------------
// A sample beat passes the memory read, stage 2 and output registers in turn.
// Throughput: one beat per cycle while the result channel is ready; the four bilinear taps
// come from two copies of the texture, each with two read ports, read in the cycle of
// acceptance. Reset clears the pipeline and sets the distance scale to 4. Texture
// contents are undefined after reset until written; there is no clearing pass.
`default_nettype none

module sdf_texture_sampler_unit import sdfts_pkg::*; #(
  parameter int TEXTURE_SIZE = TEXTURE_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [SCALE_W-1:0] cfg_wdata,
  sdfts_in_if.sink                req,
  sdfts_out_if.source             rsp
);

  localparam int DEPTH = TEXTURE_SIZE * TEXTURE_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(TEXTURE_SIZE);
  localparam int EW    = IXW - 1;
  localparam int PW    = EW + SCALE_W;

  localparam logic signed [IXW-1:0] LAST   = IXW'(TEXTURE_SIZE - 1);
  localparam logic [AW-1:0]         SIZE_A = AW'(TEXTURE_SIZE);

  function automatic logic [CW-1:0] clamp_idx(input logic signed [IXW-1:0] i);
    if (i < 0) begin
      return '0;
    end else if (i > LAST) begin
      return CW'(TEXTURE_SIZE - 1);
    end
    return i[CW-1:0];
  endfunction

  function automatic logic [EW-1:0] excess(input logic signed [IXW-1:0] i);
    logic signed [IXW-1:0] d;
    d = '0;
    if (i < 0) begin
      d = -i;
    end else if (i > LAST) begin
      d = i - LAST;
    end
    return d[EW-1:0];
  endfunction

  // a + floor((b - a) * f / 256)
  function automatic logic [CODE_W-1:0] lerp8(input logic [CODE_W-1:0] a,
                                              input logic [CODE_W-1:0] b,
                                              input logic [CODE_W-1:0] f);
    logic signed [CODE_W:0]       diff;
    logic signed [2*CODE_W+1:0]   prod;
    logic        [CODE_W+1:0]     step;
    logic        [CODE_W+1:0]     sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, f});
    step = prod[2*CODE_W+1:CODE_W];
    sum  = {2'b00, a} + step;
    return sum[CODE_W-1:0];
  endfunction

  logic [SCALE_W-1:0] scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  // Pipeline occupancy and flow.
  logic v1, v2, v3;
  logic free1, free2, free3;
  logic accept, is_sample, is_write;

  assign free3     = !v3 || rsp.ready;
  assign free2     = !v2 || free3;
  assign free1     = !v1 || free2;
  assign req.ready = free1;
  assign accept    = req.valid && free1;
  assign is_sample = (req.operation == OP_BILINEAR) || (req.operation == OP_NEAREST);
  assign is_write  = req.operation == OP_WRITE;

  // Acceptance stage: texel indices, clamping and tap addresses.
  logic [COORD_W:0]      u_round, w_round;
  logic signed [IXW-1:0] ui, wi;
  logic [CW-1:0]         cu, cw;
  logic [EW-1:0]         eu, ew, over;
  logic                  interior;
  logic [AW-1:0]         base;
  logic [AW-1:0]         addr_00, addr_01, addr_10, addr_11;
  logic                  wr_en;

  always_comb begin
    u_round = {req.coord_u[COORD_W-1], req.coord_u} + (COORD_W + 1)'(HALF_TEXEL);
    w_round = {req.coord_w[COORD_W-1], req.coord_w} + (COORD_W + 1)'(HALF_TEXEL);
    if (req.operation == OP_NEAREST) begin
      ui = $signed(u_round[COORD_W:FRAC_BITS]);
      wi = $signed(w_round[COORD_W:FRAC_BITS]);
    end else begin
      ui = $signed({req.coord_u[COORD_W-1], req.coord_u[COORD_W-1:FRAC_BITS]});
      wi = $signed({req.coord_w[COORD_W-1], req.coord_w[COORD_W-1:FRAC_BITS]});
    end
    cu       = clamp_idx(ui);
    cw       = clamp_idx(wi);
    eu       = excess(ui);
    ew       = excess(wi);
    over     = (eu > ew) ? eu : ew;
    interior = (req.operation == OP_BILINEAR) && (ui >= 0) && (ui < LAST)
               && (wi >= 0) && (wi < LAST);
    base     = AW'(cw) * SIZE_A + AW'(cu);
    addr_00  = base;
    addr_01  = interior ? base + AW'(1) : base;
    addr_10  = interior ? base + SIZE_A : base;
    addr_11  = interior ? base + SIZE_A + AW'(1) : base;
    wr_en    = accept && is_write && ({18'd0, req.texel_index} < 32'(DEPTH));
  end

  logic [CODE_W-1:0] q00, q01, q10, q11;

  sdfts_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_ram_top (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (AW'(req.texel_index)),
    .wdata   (req.texel_value),
    .re      (accept && is_sample),
    .raddr_a (addr_00),
    .raddr_b (addr_01),
    .rdata_a (q00),
    .rdata_b (q01)
  );

  sdfts_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_ram_bot (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (AW'(req.texel_index)),
    .wdata   (req.texel_value),
    .re      (accept && is_sample),
    .raddr_a (addr_10),
    .raddr_b (addr_11),
    .rdata_a (q10),
    .rdata_b (q11)
  );

  // Stage 1: taps arrive from memory.
  logic              lerp1;
  logic [CODE_W-1:0] fu1, fw1;
  logic [EW-1:0]     over1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (free1) begin
      v1 <= accept && is_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_sample) begin
      lerp1 <= interior;
      fu1   <= req.coord_u[FRAC_BITS-1 -: CODE_W];
      fw1   <= req.coord_w[FRAC_BITS-1 -: CODE_W];
      over1 <= over;
    end
  end

  logic [PW-1:0]     pen;
  logic [CODE_W:0]   pen_sat;
  logic [CODE_W-1:0] top, bot;

  always_comb begin
    pen     = PW'(over1) * PW'(scale);
    pen_sat = (pen > PW'(CODE_MAX)) ? (CODE_W + 1)'(CODE_MAX + 1) : pen[CODE_W:0];
    top     = lerp8(q00, q01, fu1);
    bot     = lerp8(q10, q11, fu1);
  end

  // Stage 2: horizontal blends and penalty are registered.
  logic              lerp2;
  logic [CODE_W-1:0] fw2, top2, bot2, edge2;
  logic [CODE_W:0]   pen2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (free2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (free2 && v1) begin
      lerp2 <= lerp1;
      fw2   <= fw1;
      top2  <= top;
      bot2  <= bot;
      edge2 <= q00;
      pen2  <= pen_sat;
    end
  end

  logic [CODE_W+1:0] edge_sum;
  logic [CODE_W-1:0] distance_next;

  always_comb begin
    edge_sum = {2'b00, edge2} + {1'b0, pen2};
    if (lerp2) begin
      distance_next = lerp8(top2, bot2, fw2);
    end else if (edge_sum > (CODE_W + 2)'(CODE_MAX)) begin
      distance_next = CODE_W'(CODE_MAX);
    end else begin
      distance_next = edge_sum[CODE_W-1:0];
    end
  end

  // Stage 3: output register.
  logic [CODE_W-1:0] distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (free3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (free3 && v2) begin
      distance <= distance_next;
    end
  end

  assign rsp.valid    = v3;
  assign rsp.distance = distance;

endmodule

`default_nettype wire

FILE: dv/sdfts_distance_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SDF texture sampler distance checker
// Watches the register port and both channels, keeps its own copy of the
// texture and the distance scale, and predicts the distance code of every
// accepted sample beat. Results are compared in order with the predictions.
// ----------------------------------------------------------------------------
module sdfts_distance_checker import sdfts_pkg::*; #(
  parameter int TEXTURE_SIZE = TEXTURE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  sdfts_in_if                req,
  sdfts_out_if               rsp,
  output int                 fails,
  output int                 pending
);

  localparam int TEXEL_COUNT = TEXTURE_SIZE * TEXTURE_SIZE;
  localparam int BLEND_BITS  = 8;

  logic [CODE_W-1:0]  texels [TEXEL_COUNT];
  logic [SCALE_W-1:0] scale;
  logic [CODE_W-1:0]  expected_distance_q [$];

  function automatic int texel(int col, int row);
    return int'(texels[row * TEXTURE_SIZE + col]);
  endfunction

  function automatic int edge_index(int i);
    if (i < 0) return 0;
    if (i > TEXTURE_SIZE - 1) return TEXTURE_SIZE - 1;
    return i;
  endfunction

  function automatic logic [CODE_W-1:0] clamped_distance(int ui, int wi);
    int cu, cw, du, dw, sum;
    cu = edge_index(ui);
    cw = edge_index(wi);
    du = (ui > cu) ? ui - cu : cu - ui;
    dw = (wi > cw) ? wi - cw : cw - wi;
    sum = texel(cu, cw) + ((du > dw) ? du : dw) * int'(scale);
    return (sum > CODE_MAX) ? CODE_W'(CODE_MAX) : CODE_W'(sum);
  endfunction

  function automatic int blend(int a, int b, int f);
    return a + (((b - a) * f) >>> BLEND_BITS);
  endfunction

  function automatic logic [CODE_W-1:0] bilinear_distance(int u, int w);
    int ui, wi, fu, fw, upper, lower;
    ui = u >>> FRAC_BITS;
    wi = w >>> FRAC_BITS;
    if (ui < 0 || ui > TEXTURE_SIZE - 2 || wi < 0 || wi > TEXTURE_SIZE - 2) begin
      return clamped_distance(ui, wi);
    end
    fu = (u >>> (FRAC_BITS - BLEND_BITS)) & ((1 << BLEND_BITS) - 1);
    fw = (w >>> (FRAC_BITS - BLEND_BITS)) & ((1 << BLEND_BITS) - 1);
    upper = blend(texel(ui, wi), texel(ui + 1, wi), fu);
    lower = blend(texel(ui, wi + 1), texel(ui + 1, wi + 1), fu);
    return CODE_W'(blend(upper, lower, fw));
  endfunction

  function automatic logic [CODE_W-1:0] nearest_distance(int u, int w);
    int ui, wi;
    ui = (u + HALF_TEXEL) >>> FRAC_BITS;
    wi = (w + HALF_TEXEL) >>> FRAC_BITS;
    if (ui < 0 || ui > TEXTURE_SIZE - 1 || wi < 0 || wi > TEXTURE_SIZE - 1) begin
      return clamped_distance(ui, wi);
    end
    return CODE_W'(texel(ui, wi));
  endfunction

  always @(posedge clk) begin : monitor
    logic [CODE_W-1:0] want;
    if (rst) begin
      scale = SCALE_RESET;
      fails = 0;
      expected_distance_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        scale = cfg_wdata;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_distance_q.size() == 0) begin
          $error("distance: result with no sample waiting, actual %0d", rsp.distance);
          fails++;
        end else begin
          want = expected_distance_q.pop_front();
          if (rsp.distance !== want) begin
            $error("distance mismatch: expected %0d, actual %0d", want, rsp.distance);
            fails++;
          end
        end
      end
      if (req.valid && req.ready) begin
        case (req.operation)
          OP_WRITE: begin
            if (int'(req.texel_index) < TEXEL_COUNT) begin
              texels[req.texel_index] = req.texel_value;
            end
          end
          OP_BILINEAR: begin
            expected_distance_q.push_back(
              bilinear_distance(int'(req.coord_u), int'(req.coord_w)));
          end
          OP_NEAREST: begin
            expected_distance_q.push_back(
              nearest_distance(int'(req.coord_u), int'(req.coord_w)));
          end
          default: ;
        endcase
      end
      pending <= expected_distance_q.size();
    end
  end

endmodule

FILE: dv/sdf_texture_sampler_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SDF texture sampler testbench
// Loads texels before any sample reads them, then sends directed corner cases
// and random bilinear and nearest samples under several distance scales and
// idling mixes. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sdf_texture_sampler_unit_test import sdfts_pkg::*; ();

  localparam int TEX_SIZE        = TEXTURE_SIZE_DEF;
  localparam int TEXEL_COUNT     = TEX_SIZE * TEX_SIZE;
  localparam int TEXEL_ONE       = 1 << FRAC_BITS;
  localparam int COORD_MIN       = -(1 << (COORD_W - 1));
  localparam int COORD_MAX       = (1 << (COORD_W - 1)) - 1;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PATCH_TEXELS    = 8;
  localparam int PHASE_BEATS     = 250;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [SCALE_W-1:0] cfg_wdata;

  sdfts_in_if  req_if ();
  sdfts_out_if rsp_if ();

  int fails;
  int pending;
  int quiet_cycles;
  int send_gap_pct;
  int ready_stall_pct;
  bit hold_off_request;
  bit texel_loaded [TEXEL_COUNT];
  int beats_sent;
  int writes_sent;
  int bilinear_sent;
  int nearest_sent;
  int ignored_sent;
  int patch_col;
  int patch_row;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sdf_texture_sampler_unit #(
    .TEXTURE_SIZE (TEX_SIZE)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  sdfts_distance_checker #(
    .TEXTURE_SIZE (TEX_SIZE)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if),
    .fails     (fails),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      rsp_if.ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  function automatic int edge_index(int i);
    if (i < 0) return 0;
    if (i > TEX_SIZE - 1) return TEX_SIZE - 1;
    return i;
  endfunction

  function automatic int full_coord();
    logic signed [COORD_W-1:0] c;
    c = COORD_W'($urandom);
    return int'(c);
  endfunction

  function automatic int patch_coord(int origin);
    return origin * TEXEL_ONE + $urandom_range(0, PATCH_TEXELS * TEXEL_ONE - 1);
  endfunction

  function automatic int border_coord();
    int picks [5];
    picks = '{-1, 0, TEX_SIZE - 2, TEX_SIZE - 1, TEX_SIZE};
    return picks[$urandom_range(4)] * TEXEL_ONE + $urandom_range(0, TEXEL_ONE - 1);
  endfunction

  task automatic send_beat(logic [OP_W-1:0] op, int u, int w,
                           logic [INDEX_W-1:0] idx, logic [CODE_W-1:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.coord_u     <= COORD_W'(u);
    req_if.coord_w     <= COORD_W'(w);
    req_if.texel_index <= idx;
    req_if.texel_value <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    case (op)
      OP_WRITE:    writes_sent++;
      OP_BILINEAR: bilinear_sent++;
      OP_NEAREST:  nearest_sent++;
      default:     ignored_sent++;
    endcase
    if (op != OP_UNUSED) begin
      beats_sent++;
    end
  endtask

  task automatic load_texel(int idx, logic [CODE_W-1:0] val);
    send_beat(OP_WRITE, full_coord(), full_coord(), INDEX_W'(idx), val);
    texel_loaded[idx] = 1'b1;
  endtask

  task automatic ensure_texel(int col, int row);
    if (!texel_loaded[row * TEX_SIZE + col]) begin
      load_texel(row * TEX_SIZE + col, CODE_W'($urandom));
    end
  endtask

  task automatic sample(logic [OP_W-1:0] op, int u, int w);
    int ui, wi;
    if (op == OP_BILINEAR) begin
      ui = u >>> FRAC_BITS;
      wi = w >>> FRAC_BITS;
    end else begin
      ui = (u + HALF_TEXEL) >>> FRAC_BITS;
      wi = (w + HALF_TEXEL) >>> FRAC_BITS;
    end
    if (op == OP_BILINEAR && ui >= 0 && ui <= TEX_SIZE - 2 && wi >= 0 && wi <= TEX_SIZE - 2) begin
      for (int dr = 0; dr < 2; dr++) begin
        for (int dc = 0; dc < 2; dc++) begin
          ensure_texel(ui + dc, wi + dr);
        end
      end
    end else begin
      ensure_texel(edge_index(ui), edge_index(wi));
    end
    send_beat(op, u, w, INDEX_W'($urandom), CODE_W'($urandom));
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_traffic(int beats, int hold_at, int drain_at);
    int start, pick;
    logic [OP_W-1:0] op;
    start = beats_sent;
    patch_col = $urandom_range(0, TEX_SIZE - 1);
    patch_row = $urandom_range(0, TEX_SIZE - 1);
    while (beats_sent - start < beats) begin
      if (hold_at >= 0 && beats_sent - start >= hold_at) begin
        hold_off_request = 1'b1;
        hold_at = -1;
      end
      if (drain_at >= 0 && beats_sent - start >= drain_at) begin
        drain();
        drain_at = -1;
      end
      pick = $urandom_range(99);
      op = $urandom_range(1) ? OP_NEAREST : OP_BILINEAR;
      if (pick < 12) begin
        load_texel(edge_index(patch_row + $urandom_range(0, PATCH_TEXELS)) * TEX_SIZE
                   + edge_index(patch_col + $urandom_range(0, PATCH_TEXELS)),
                   CODE_W'($urandom));
      end else if (pick < 18) begin
        load_texel($urandom_range(0, TEXEL_COUNT - 1), CODE_W'($urandom));
      end else if (pick < 20) begin
        send_beat(OP_UNUSED, full_coord(), full_coord(), INDEX_W'($urandom), CODE_W'($urandom));
      end else if (pick < 70) begin
        sample(op, patch_coord(patch_col), patch_coord(patch_row));
      end else if (pick < 85) begin
        sample(op, full_coord(), full_coord());
      end else begin
        sample(op, border_coord(), border_coord());
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_if.valid       <= 1'b0;
    req_if.operation   <= OP_WRITE;
    req_if.coord_u     <= '0;
    req_if.coord_w     <= '0;
    req_if.texel_index <= '0;
    req_if.texel_value <= '0;
    send_gap_pct    = 0;
    ready_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    load_texel(0, 8'd0);
    load_texel(TEXEL_COUNT - 1, 8'd255);
    load_texel(20 * TEX_SIZE + 10, 8'd0);
    load_texel(20 * TEX_SIZE + 11, 8'd255);
    load_texel(21 * TEX_SIZE + 10, 8'd255);
    load_texel(21 * TEX_SIZE + 11, 8'd0);
    sample(OP_BILINEAR, 10 * TEXEL_ONE + TEXEL_ONE - 1, 20 * TEXEL_ONE + TEXEL_ONE - 1);
    sample(OP_BILINEAR, 0, 0);
    sample(OP_NEAREST, 5 * TEXEL_ONE + HALF_TEXEL, 7 * TEXEL_ONE + HALF_TEXEL - 1);
    sample(OP_BILINEAR, (TEX_SIZE - 1) * TEXEL_ONE + 'h8F0, 3 * TEXEL_ONE + 'h400);
    sample(OP_NEAREST, (TEX_SIZE - 1) * TEXEL_ONE + HALF_TEXEL - 1, 0);
    sample(OP_NEAREST, (TEX_SIZE - 1) * TEXEL_ONE + HALF_TEXEL, 0);
    sample(OP_BILINEAR, -1, 2 * TEXEL_ONE);
    sample(OP_NEAREST, -HALF_TEXEL, -HALF_TEXEL - 1);
    sample(OP_BILINEAR, COORD_MIN, COORD_MAX);
    sample(OP_NEAREST, COORD_MAX, COORD_MIN);
    send_beat(OP_UNUSED, COORD_MAX, COORD_MIN, INDEX_W'($urandom), CODE_W'($urandom));

    write_scale(8'd255);
    random_traffic(PHASE_BEATS, 100, -1);

    write_scale(8'd1);
    send_gap_pct = 77;
    random_traffic(PHASE_BEATS, -1, -1);

    write_scale(8'd0);
    send_gap_pct    = 0;
    ready_stall_pct = 77;
    random_traffic(PHASE_BEATS, -1, 120);

    write_scale(SCALE_W'($urandom_range(2, 254)));
    send_gap_pct    = 10;
    ready_stall_pct = 10;
    random_traffic(PHASE_BEATS, -1, -1);

    write_scale(SCALE_W'($urandom));
    send_gap_pct    = 0;
    ready_stall_pct = 0;
    random_traffic(PHASE_BEATS, -1, -1);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d texel writes, %0d bilinear and %0d nearest samples, %0d unused beats.",
             writes_sent, bilinear_sent, nearest_sent, ignored_sent);
    $display("Scales covered reset, 255, 1, 0 and random; idling mixes with hold-off and drain.");
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
